// ===== hdl/hda_pkg.sv =====
// Shared constants and controller/datapath interface types for the Hassanat distance block.
package hda_pkg;

    localparam int SUM_WIDTH       = 29;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_LEN_DEF     = 4096;

    typedef struct packed {
        logic load;
        logic step;
        logic accum;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

// ===== hdl/hda_datapath.sv =====
// Datapath: operand setup, restoring fraction divider, saturating accumulator and result register.
module hda_datapath #(
    parameter int VALUE_WIDTH = 16,
    parameter int FRAC_BITS   = 16,
    parameter int MAX_LEN     = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hda_pkg::cmd_t                 cmd,
    output hda_pkg::status_t              status,
    input  logic [VALUE_WIDTH-1:0]        first_value,
    input  logic [VALUE_WIDTH-1:0]        second_value,
    input  logic                          last_element,
    output logic [hda_pkg::SUM_WIDTH-1:0] distance
);
    import hda_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam logic [63:0] SUM_MASK  = (64'd1 << SUM_WIDTH) - 64'd1;
    localparam logic [63:0] CEIL_WIDE = 64'(MAX_LEN) << FRAC_BITS;
    localparam logic [SUM_WIDTH-1:0] SUM_CEIL =
        (CEIL_WIDE > SUM_MASK) ? SUM_WIDTH'(SUM_MASK) : SUM_WIDTH'(CEIL_WIDE);

    logic [VW:0]            rem_reg, rem_next;
    logic [VW:0]            den_reg, den_next;
    logic [FRAC_BITS-1:0]   quot_reg, quot_next;
    logic                   last_reg, last_next;
    logic [SUM_WIDTH-1:0]   sum_reg, sum_next;
    logic [SUM_WIDTH-1:0]   dist_reg, dist_next;

    logic signed [VW-1:0]   a_val, b_val, mn, mx;
    logic signed [VW:0]     diff_w;
    logic [VW:0]            den_w;
    logic [VW+1:0]          rem2, trial;
    logic                   take;
    logic [SUM_WIDTH:0]     total;
    logic [SUM_WIDTH-1:0]   sat_sum;

    always_comb
    begin
        a_val  = $signed(first_value);
        b_val  = $signed(second_value);
        mn     = (a_val < b_val) ? a_val : b_val;
        mx     = (a_val < b_val) ? b_val : a_val;
        diff_w = {mx[VW-1], mx} - {mn[VW-1], mn};
        if (!mn[VW-1])
        begin
            den_w = {1'b0, mx} + (VW+1)'(1);
        end
        else
        begin
            den_w = {1'b0, diff_w[VW-1:0]} + (VW+1)'(1);
        end

        rem2  = {rem_reg, 1'b0};
        trial = rem2 - {1'b0, den_reg};
        take  = !trial[VW+1];

        total   = {1'b0, sum_reg} + (SUM_WIDTH+1)'(quot_reg);
        sat_sum = (total > {1'b0, SUM_CEIL}) ? SUM_CEIL : total[SUM_WIDTH-1:0];

        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        last_next = last_reg;
        sum_next  = sum_reg;
        dist_next = dist_reg;

        if (cmd.load)
        begin
            rem_next  = {1'b0, diff_w[VW-1:0]};
            den_next  = den_w;
            quot_next = '0;
            last_next = last_element;
        end
        if (cmd.step)
        begin
            rem_next  = take ? trial[VW:0] : rem2[VW:0];
            quot_next = {quot_reg[FRAC_BITS-2:0], take};
        end
        if (cmd.accum)
        begin
            if (last_reg)
            begin
                dist_next = sat_sum;
                sum_next  = '0;
            end
            else
            begin
                sum_next = sat_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        last_reg <= last_next;
        dist_reg <= dist_next;
    end

    assign status.last = last_reg;
    assign distance    = dist_reg;

`ifndef SYNTHESIS
    a_sum_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_CEIL)
        else $error("running sum exceeds its ceiling");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> rem_reg < den_reg)
        else $error("divider remainder not below denominator");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> den_reg != '0)
        else $error("zero denominator loaded");
`endif

endmodule

// ===== hdl/hda_ctrl.sv =====
// Controller: request handshakes, divide step counter and sequencing of the datapath.
module hda_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output hda_pkg::cmd_t    cmd,
    input  hda_pkg::status_t status
);
    import hda_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DIVIDE = 3'b010,
        S_ACCUM  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept, out_free, cnt_done;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_done = (cnt_reg == CNT_W'(FRAC_BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_done)
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                if (!status.last || out_free)
                begin
                    cmd.accum  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (cmd.accum && status.last) ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_rose_after_accum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_ACCUM && status.last))
        else $error("result raised outside the accumulate step of a last element");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum && status.last |-> out_free)
        else $error("result register overwritten while stalled");

    a_divide_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIVIDE && cnt_done |=> state_reg == S_ACCUM)
        else $error("divide phase did not end after its last step");
`endif

endmodule

// ===== hdl/hassanat_distance_accumulator.sv =====
// Top level of the Hassanat distance accumulator.
// Usage: the input channel (in_valid, in_stall) carries one element pair of two
// signed vectors per request, first_value and second_value, with last_element set
// on the final pair. Each pair contributes a fraction term with FRAC_BITS fraction
// bits to a running sum that saturates at MAX_LEN << FRAC_BITS, capped at 2^29-1.
// The output channel (out_valid, out_stall) carries one distance request per vector,
// issued after its last pair; the running sum is then cleared.
// Each pair is handled in order: the operands are set up, the radix-2 restoring
// divider forms the FRAC_BITS fraction bits one per step, and the term is
// accumulated. The next pair is accepted in the cycle after the accumulate step.
// A distance is held in an output register from the accumulate step of its last
// pair, so further pairs are accepted while it waits.
// If the receiver still stalls a previous distance when a new last pair reaches
// its accumulate step, that step waits until the output register is free.
// Reset clears the running sum, the controller and the output valid.
module hassanat_distance_accumulator #(
    parameter int VALUE_WIDTH = hda_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = hda_pkg::FRAC_BITS_DEF,
    parameter int MAX_LEN     = hda_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [VALUE_WIDTH-1:0]        first_value,
    input  logic [VALUE_WIDTH-1:0]        second_value,
    input  logic                          last_element,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hda_pkg::SUM_WIDTH-1:0] distance
);
    import hda_pkg::*;

    cmd_t    cmd;
    status_t status;

    hda_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    hda_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .MAX_LEN     (MAX_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .first_value  (first_value),
        .second_value (second_value),
        .last_element (last_element),
        .distance     (distance)
    );

endmodule
